/* rtl/gffc_pkg.sv */
// gffc_pkg: shared constants, payload structs and types for the gated frequency counter
// no dependencies
`timescale 1ns / 1ps
package gffc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int PERIOD_W    = 16;
  localparam int GLITCH_W    = 8;
  localparam int TS_W        = 32;
  localparam int OUT_W       = 32;

  localparam int FREQ_SCALE  = 1000;
  localparam int SCALE_W     = $clog2(FREQ_SCALE + 1);
  localparam int DIV_W       = COUNT_WIDTH + SCALE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [GLITCH_W-1:0] GLITCH_RESET = GLITCH_W'(5);

  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GLITCH = 1'b1;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [TS_W-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] latched_count;
    logic [OUT_W-1:0] frequency_hz;
    logic             gate_closed;
  } out_item_t;

  typedef struct packed {
    logic                   closed;
    logic [COUNT_WIDTH-1:0] count;
    logic [PERIOD_W-1:0]    period;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT
  } bstate_t;

endpackage

/* rtl/glitch_filtered_frequency_counter_core.sv */
// glitch_filtered_frequency_counter_core: top level, front, job queue and back part
// depends on gffc_pkg, gffc_front, gffc_fifo, gffc_back
// an edge or a non-closing tick passes from acceptance through the job queue and then the result register
// a gate-closing tick runs a bit-serial divide, one bit of count*1000/period per cycle
// throughput: one item per cycle while the 4-entry queue has room; each closing tick
// holds the back part for its divide, and items queue up behind it
// reset: synchronous active-low rst_n clears counters, held values and the queue;
// the gate period returns to 1000 and the minimum edge spacing to 5
`timescale 1ns / 1ps
module glitch_filtered_frequency_counter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gffc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gffc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gffc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gffc_pkg::out_item_t             out_data
);
  import gffc_pkg::*;

  q_stat_t q_stat;
  job_t    push_job;
  job_t    head_job;
  logic    push;
  logic    pop;

  gffc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  gffc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  gffc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/gffc_front.sv */
// gffc_front: config registers, glitch filter, edge and tick counters, job generation
// depends on gffc_pkg
`timescale 1ns / 1ps
module gffc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gffc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gffc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gffc_pkg::in_item_t             in_data,
  input  gffc_pkg::q_stat_t              q_stat,
  output logic                           push,
  output gffc_pkg::job_t                 push_job
);
  import gffc_pkg::*;

  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [GLITCH_W-1:0]    glitch_r, glitch_nxt;
  logic [PERIOD_W-1:0]    tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] edge_r, edge_nxt;
  logic [TIME_WIDTH-1:0]  last_r, last_nxt;

  logic [TIME_WIDTH-1:0]  ts;
  logic [TIME_WIDTH-1:0]  diff;
  logic [PERIOD_W-1:0]    tick_inc;
  logic [PERIOD_W-1:0]    eff_period;
  logic                   accept;
  logic                   close;

  assign in_stall   = q_stat.full;
  assign accept     = in_valid && !q_stat.full;
  assign ts         = TIME_WIDTH'(in_data.timestamp_us);
  assign diff       = ts - last_r;
  assign tick_inc   = tick_r + PERIOD_W'(1);
  assign eff_period = (period_r == '0) ? PERIOD_W'(1) : period_r;
  assign close      = (in_data.operation == OP_TICK) && (tick_inc >= eff_period);

  always_comb begin
    period_nxt = period_r;
    glitch_nxt = glitch_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD: period_nxt = cfg_wdata[PERIOD_W-1:0];
        CFG_GLITCH: glitch_nxt = cfg_wdata[GLITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_nxt = tick_r;
    edge_nxt = edge_r;
    last_nxt = last_r;
    if (accept) begin
      if (in_data.operation == OP_EDGE) begin
        if (diff >= TIME_WIDTH'(glitch_r)) begin
          if (edge_r != '1) edge_nxt = edge_r + COUNT_WIDTH'(1);
          last_nxt = ts;
        end
      end else if (close) begin
        tick_nxt = '0;
        edge_nxt = '0;
      end else begin
        tick_nxt = tick_inc;
      end
    end
  end

  assign push            = accept;
  assign push_job.closed = close;
  assign push_job.count  = edge_r;
  assign push_job.period = eff_period;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      glitch_r <= GLITCH_RESET;
      tick_r   <= '0;
      edge_r   <= '0;
      last_r   <= '0;
    end else begin
      period_r <= period_nxt;
      glitch_r <= glitch_nxt;
      tick_r   <= tick_nxt;
      edge_r   <= edge_nxt;
      last_r   <= last_nxt;
    end
  end

endmodule

/* rtl/gffc_fifo.sv */
// gffc_fifo: short job queue between the front and back parts
// depends on gffc_pkg
`timescale 1ns / 1ps
module gffc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gffc_pkg::job_t    push_job,
  input  logic              pop,
  output gffc_pkg::job_t    head_job,
  output gffc_pkg::q_stat_t q_stat
);
  import gffc_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/gffc_back.sv */
// gffc_back: held values, bit-serial frequency divider and result register
// depends on gffc_pkg
`timescale 1ns / 1ps
module gffc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gffc_pkg::q_stat_t   q_stat,
  input  gffc_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output gffc_pkg::out_item_t out_data
);
  import gffc_pkg::*;

  bstate_t                state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] held_count_r, held_count_nxt;
  logic [OUT_W-1:0]       held_freq_r, held_freq_nxt;
  logic [DIV_W-1:0]       dq_r, dq_nxt;
  logic [PERIOD_W-1:0]    rem_r, rem_nxt;
  logic [PERIOD_W-1:0]    div_r, div_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   out_free;
  logic [PERIOD_W:0]      rem_sh;
  logic [PERIOD_W:0]      trial;
  logic                   fits;

  function automatic logic [OUT_W-1:0] sat_count(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH-1:0] hi;
    hi = v >> OUT_W;
    return (hi != '0) ? '1 : OUT_W'(v);
  endfunction

  function automatic logic [OUT_W-1:0] sat_quot(input logic [DIV_W-1:0] v);
    logic [DIV_W-1:0] hi;
    hi = v >> OUT_W;
    return (hi != '0) ? '1 : OUT_W'(v);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == B_IDLE) && !q_stat.empty && (head_job.closed || out_free);
  assign rem_sh   = {rem_r, dq_r[DIV_W-1]};
  assign trial    = rem_sh - {1'b0, div_r};
  assign fits     = rem_sh >= {1'b0, div_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (pop && head_job.closed) state_nxt = B_DIV;
      B_DIV:  if (cnt_r == DIV_CNT_W'(1)) state_nxt = B_EMIT;
      B_EMIT: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    held_count_nxt = held_count_r;
    held_freq_nxt  = held_freq_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop) begin
          if (head_job.closed) begin
            held_count_nxt = head_job.count;
            dq_nxt  = DIV_W'(head_job.count) * DIV_W'(FREQ_SCALE);
            rem_nxt = '0;
            div_nxt = head_job.period;
            cnt_nxt = DIV_CNT_W'(DIV_W);
          end else begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.latched_count = sat_count(held_count_r);
            out_data_nxt.frequency_hz  = held_freq_r;
            out_data_nxt.gate_closed   = 1'b0;
          end
        end
      end
      B_DIV: begin
        rem_nxt = fits ? trial[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
        dq_nxt  = {dq_r[DIV_W-2:0], fits};
        cnt_nxt = cnt_r - DIV_CNT_W'(1);
      end
      B_EMIT: begin
        if (out_free) begin
          held_freq_nxt              = sat_quot(dq_r);
          out_valid_nxt              = 1'b1;
          out_data_nxt.latched_count = sat_count(held_count_r);
          out_data_nxt.frequency_hz  = sat_quot(dq_r);
          out_data_nxt.gate_closed   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      held_count_r <= '0;
      held_freq_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_count_r <= held_count_nxt;
      held_freq_r  <= held_freq_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

/* rtl/gffc_checker.sv */
// gffc_checker: port-level assertions for the frequency counter top level
// depends on gffc_pkg; bound to glitch_filtered_frequency_counter_core
`timescale 1ns / 1ps
module gffc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input gffc_pkg::out_item_t out_data
);
  import gffc_pkg::*;

  logic [3:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions in flight
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) pend_nxt = pend_r + 4'd1;
    else if (out_acc && !in_acc) pend_nxt = pend_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_nxt;
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without an outstanding transaction");

  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.latched_count == '0 |-> out_data.frequency_hz == '0)
    else $error("nonzero frequency for zero count");

endmodule

bind glitch_filtered_frequency_counter_core gffc_checker u_gffc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/glitch_filtered_frequency_counter_core_test.sv */
// glitch_filtered_frequency_counter_core_test: self-checking bench for the gated counter core
// drives a directed table, then random edge/tick traffic, and checks every result in order
// depends on gffc_pkg and glitch_filtered_frequency_counter_core
`timescale 1ns / 1ps
module glitch_filtered_frequency_counter_core_test;
  import gffc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASE_ITEMS    = 300;
  localparam int NUM_PHASES     = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;

  glitch_filtered_frequency_counter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 op;
    logic [31:0]          value;
    bit                   typed;
    out_item_t            ex;
  } stim_row_t;

  // mirror of the counter state
  logic [PERIOD_W-1:0]    m_period = PERIOD_RESET;
  logic [GLITCH_W-1:0]    m_glitch = GLITCH_RESET;
  logic [PERIOD_W-1:0]    m_ticks = '0;
  logic [COUNT_WIDTH-1:0] m_edges = '0;
  logic [TIME_WIDTH-1:0]  m_last = '0;
  logic [OUT_W-1:0]       m_held_count = '0;
  logic [OUT_W-1:0]       m_held_freq = '0;

  out_item_t   pending_readings[$];
  stim_row_t   dir_rows[$];
  int          errors = 0;
  int          mismatches = 0;
  int          tx_idle_pct = 15;
  int          rx_idle_pct = 81;
  bit          hold_req = 1'b0;
  bit          drv_typed;
  out_item_t   drv_exp;
  logic [31:0] stamp = '0;
  logic [7:0]  cur_glitch = GLITCH_RESET;

  function automatic out_item_t counter_step(in_item_t it);
    out_item_t             r;
    logic [PERIOD_W-1:0]   t;
    logic [TIME_WIDTH-1:0] diff;
    logic [PERIOD_W:0]     eff;
    logic [63:0]           prod;
    r.gate_closed = 1'b0;
    if (it.operation == OP_EDGE) begin
      diff = it.timestamp_us - m_last;
      if (diff >= TIME_WIDTH'(m_glitch)) begin
        if (m_edges != '1) m_edges = m_edges + 1'b1;
        m_last = it.timestamp_us;
      end
    end else begin
      t = m_ticks + 1'b1;
      eff = (m_period == '0) ? (PERIOD_W+1)'(1) : {1'b0, m_period};
      if ({1'b0, t} >= eff) begin
        m_held_count = m_edges;
        prod = 64'(m_edges) * 64'(FREQ_SCALE);
        prod = prod / 64'(eff);
        m_held_freq = (prod > 64'hFFFF_FFFF) ? '1 : prod[31:0];
        m_edges = '0;
        m_ticks = '0;
        r.gate_closed = 1'b1;
      end else begin
        m_ticks = t;
      end
    end
    r.latched_count = m_held_count;
    r.frequency_hz = m_held_freq;
    return r;
  endfunction

  function automatic stim_row_t mk_row(bit is_cfg, logic [CFG_IDX_W-1:0] idx, logic op,
                                       logic [31:0] value, bit typed, logic [31:0] cnt,
                                       logic [31:0] frq, logic cl);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.reg_idx = idx;
    row.op = op;
    row.value = value;
    row.typed = typed;
    row.ex.latched_count = cnt;
    row.ex.frequency_hz = frq;
    row.ex.gate_closed = cl;
    return row;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // check results first, then record the transaction accepted at the same edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == CFG_PERIOD) m_period = cfg_wdata[PERIOD_W-1:0];
        else if (cfg_index == CFG_GLITCH) m_glitch = cfg_wdata[GLITCH_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected result: count %0d freq %0d closed %0b",
                     out_data.latched_count, out_data.frequency_hz, out_data.gate_closed);
          mismatches++;
        end else begin
          want = pending_readings.pop_front();
          if (out_data.latched_count !== want.latched_count ||
              out_data.frequency_hz !== want.frequency_hz ||
              out_data.gate_closed !== want.gate_closed) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: expected count %0d freq %0d closed %0b, got %0d %0d %0b",
                       want.latched_count, want.frequency_hz, want.gate_closed,
                       out_data.latched_count, out_data.frequency_hz, out_data.gate_closed);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = counter_step(in_data);
        if (drv_typed) want = drv_exp;
        pending_readings.push_back(want);
      end
    end
  end

  // receiver: random stall, plus one long hold when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic drain_readings();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_readings();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic offer_item(in_item_t it, bit typed, out_item_t ex);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    drv_typed <= typed;
    drv_exp <= ex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    in_item_t   it;
    int         r;
    logic [15:0] p;
    logic [7:0]  g;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    drv_typed = 1'b0;
    drv_exp = '0;

    // edges below the glitch spacing right after reset are dropped
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0000, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0004, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0005, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(1, CFG_PERIOD, OP_EDGE, 32'd1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'hFFFF_FFFF, 1, 1, 1000, 1));
    // timestamp wrap
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'hFFFF_FFFF, 1, 1, 1000, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0003, 1, 1, 1000, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0004, 1, 1, 1000, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 2, 2000, 1));
    dir_rows.push_back(mk_row(1, CFG_GLITCH, OP_EDGE, 32'd0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0004, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0004, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(1, CFG_GLITCH, OP_EDGE, 32'd255, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0102, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h0000_0103, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h5A5A_5A5A, 1, 3, 3000, 1));
    // zero period acts as one
    dir_rows.push_back(mk_row(1, CFG_PERIOD, OP_EDGE, 32'd0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'hAAAA_AAAA, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 1, 1000, 1));
    dir_rows.push_back(mk_row(1, CFG_PERIOD, OP_EDGE, 32'd65535, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_EDGE, 32'h5555_5555, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 1, 1000, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 1, 1000, 0));
    // period lowered mid gate closes on the next tick
    dir_rows.push_back(mk_row(1, CFG_PERIOD, OP_EDGE, 32'd2, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(0, CFG_PERIOD, OP_TICK, 32'h0000_0000, 1, 1, 500, 1));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value[CFG_DATA_W-1:0]);
      end else begin
        it.operation = dir_rows[i].op;
        it.timestamp_us = dir_rows[i].value;
        offer_item(it, dir_rows[i].typed, dir_rows[i].ex);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          p = 16'd3;
          g = 8'd0;
        end
        1: begin
          p = 16'd1;
          g = 8'd255;
        end
        2: begin
          p = 16'd0;
          g = 8'd17;
        end
        3: begin
          p = 16'd10;
          g = 8'd5;
        end
        4: begin
          p = 16'd65535;
          g = 8'd128;
        end
        default: begin
          p = 16'($urandom_range(1, 30));
          g = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_PERIOD, p);
      write_reg(CFG_GLITCH, {8'($urandom_range(0, 255)), g});
      cur_glitch = g;
      if (ph == 0 || ph == NUM_PHASES - 1) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(99);
        it.timestamp_us = $urandom();
        if (r < 18) begin
          it.operation = OP_TICK;
        end else begin
          it.operation = OP_EDGE;
          if (r < 88) stamp = stamp + $urandom_range(0, 2 * int'(cur_glitch) + 2);
          else if (r < 95) stamp = $urandom();
          else stamp = stamp - $urandom_range(0, 300);
          it.timestamp_us = stamp;
        end
        offer_item(it, 1'b0, '0);
      end
    end

    drain_readings();
    repeat (60) @(negedge clk);
    if (errors == 0 && pending_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gffc_pkg.sv
rtl/gffc_front.sv
rtl/gffc_fifo.sv
rtl/gffc_back.sv
rtl/glitch_filtered_frequency_counter_core.sv
rtl/gffc_checker.sv
tb/glitch_filtered_frequency_counter_core_test.sv
